// ===== rtl/cqe_pkg.sv =====
// ----------------------------------------------------------------------------
// cqe_pkg: shared types and constants for the circular queue engine
// Command and status codes, fixed field widths, and the bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cqe_pkg;

  localparam int WORD_W = 32;
  localparam int CAP_W  = 7;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_DISP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;   // capture the accepted word and start the cursor at the head
    logic exec;    // enqueue, or produce an overflow or empty result
    logic fetch;   // build a result from the registered memory read data
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_enq;
    logic is_disp;
    logic q_empty;
    logic res_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/cqe_datapath.sv =====
// ----------------------------------------------------------------------------
// cqe_datapath: queue storage, pointers and result register
// Holds the ring memory, head, tail, occupancy, capacity and the display
// cursor, and builds each result word on command from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module cqe_datapath #(
  parameter int DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cqe_pkg::ctrl_cmd_t          ctrl,
  output cqe_pkg::dp_status_t              stat,
  input  wire logic                        cfg_we,
  input  wire logic [cqe_pkg::CAP_W-1:0]   cfg_capacity,
  input  wire logic [1:0]                  cmd,
  input  wire logic signed [cqe_pkg::WORD_W-1:0] push_value,
  output logic signed [cqe_pkg::WORD_W-1:0] value,
  output logic signed [cqe_pkg::WORD_W-1:0] rear_value,
  output logic [1:0]                       status,
  output logic                             last,
  output logic                             full_res,
  output logic                             empty_res
);
  import cqe_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_front;
  logic [WORD_W-1:0] rd_rear;

  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     cursor;
  logic [CW-1:0]     occ;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cap;
  cmd_t              cmd_q;
  logic [WORD_W-1:0] push_q;

  logic [CW-1:0]     cap_clamped;
  logic [AW-1:0]     rear_addr;
  logic              q_full;
  logic              q_empty;
  logic [CW-1:0]     count_inc;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i,
                                              input logic [CW-1:0] c);
    logic [CW-1:0] n;
    n = {1'b0, i} + CW'(1);
    return (n >= c) ? '0 : n[AW-1:0];
  endfunction

  always_comb begin
    if (cfg_capacity == '0) begin
      cap_clamped = CW'(1);
    end else if (cfg_capacity > CAP_W'(DEPTH)) begin
      cap_clamped = CW'(DEPTH);
    end else begin
      cap_clamped = cfg_capacity[CW-1:0];
    end
  end

  // The rear word sits one slot behind the tail, wrapping at the capacity.
  assign rear_addr = (tail == '0) ? AW'(cap - CW'(1)) : tail - AW'(1);
  assign q_full    = (occ >= cap);
  assign q_empty   = (occ == '0);
  assign count_inc = count + CW'(1);

  assign full_res  = q_full;
  assign empty_res = q_empty;

  assign stat.is_enq   = (cmd_q == CMD_ENQ);
  assign stat.is_disp  = (cmd_q == CMD_DISP);
  assign stat.q_empty  = q_empty;
  assign stat.res_last = last;

  // Both read ports run every cycle; the controller fetches the registered data in its read state.
  always_ff @(posedge clk) begin
    rd_front <= mem[cursor];
    rd_rear  <= mem[rear_addr];
    if (ctrl.exec && (cmd_q == CMD_ENQ) && !q_full) begin
      mem[tail] <= push_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_q  <= cmd_t'(cmd);
      push_q <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      occ    <= '0;
      cap    <= CW'(DEPTH);
      cursor <= '0;
      count  <= '0;
    end else if (cfg_we) begin
      head   <= '0;
      tail   <= '0;
      occ    <= '0;
      cap    <= cap_clamped;
    end else if (ctrl.latch) begin
      cursor <= head;
      count  <= '0;
    end else if (ctrl.exec) begin
      if ((cmd_q == CMD_ENQ) && !q_full) begin
        tail <= next_idx(tail, cap);
        occ  <= occ + CW'(1);
      end
    end else if (ctrl.fetch) begin
      case (cmd_q)
        CMD_DEQ: begin
          occ <= occ - CW'(1);
          if (occ == CW'(1)) begin
            head <= '0;
            tail <= '0;
          end else begin
            head <= next_idx(head, cap);
          end
        end
        CMD_DISP: begin
          cursor <= next_idx(cursor, cap);
          count  <= count_inc;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      value      <= '0;
      rear_value <= '0;
      last       <= 1'b1;
      if (cmd_q == CMD_ENQ) begin
        status <= q_full ? ST_OVERFLOW : ST_OK;
      end else begin
        status <= ST_EMPTY;
      end
    end else if (ctrl.fetch) begin
      value      <= rd_front;
      rear_value <= (cmd_q == CMD_PEEK) ? rd_rear : '0;
      status     <= ST_OK;
      last       <= (cmd_q == CMD_DISP) ? (count_inc == occ) : 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cqe_ctrl.sv =====
// ----------------------------------------------------------------------------
// cqe_ctrl: command sequencer for the circular queue engine
// Steps each accepted word through execute, memory read and output (enqueue
// and empty results skip the read), and repeats the read and output steps
// for every word of a display run.
`default_nettype none

module cqe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire cqe_pkg::dp_status_t stat,
  output cqe_pkg::ctrl_cmd_t       ctrl
);
  import cqe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign ctrl.latch = in_valid && in_ready;
  assign ctrl.exec  = (state == S_EXEC) && (stat.is_enq || stat.q_empty);
  assign ctrl.fetch = (state == S_READ);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = (stat.is_enq || stat.q_empty) ? S_OUT : S_READ;
      end
      S_READ: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        // The cursor has already moved on, so the next display word is
        // in the read register once the read state is entered again.
        if (out_ready) begin
          state_next = (stat.is_disp && !stat.res_last) ? S_READ : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/circular_queue_engine.sv =====
// ----------------------------------------------------------------------------
// circular_queue_engine: ring-buffer queue of signed 32-bit words
// Enqueue, dequeue, peek and display commands over a queue whose usable
// capacity is a writable register.
// ----------------------------------------------------------------------------
// Usage. A command word (cmd, push_value) enters on in_valid/in_ready and
// its results leave on out_valid/out_ready, one word per result. Every
// result carries the full and empty flags as they stand after the command.
// The capacity port is to be written only while the engine is idle; the
// block itself does not enforce this. Writing it empties the queue. Zero
// acts as one and values above DEPTH act as DEPTH.
// Timing. The engine works on one command at a time and takes no new one
// until the last result has gone; in_ready returns the cycle after that.
// Enqueue and every overflow or empty result go from the execute state
// straight to output, while dequeue and peek pass through a read state
// first, as the ring memory has a registered read port. A display run
// passes through the read state before each word it offers, returning
// there each time a word other than the last is taken.
// Reset leaves the queue empty with the capacity at DEPTH. A stalled
// receiver simply holds the result in place; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_queue_engine #(
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cqe_pkg::CAP_W-1:0]        capacity,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       cmd,
  input  wire logic signed [cqe_pkg::WORD_W-1:0] push_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [cqe_pkg::WORD_W-1:0]     value,
  output logic signed [cqe_pkg::WORD_W-1:0]     rear_value,
  output logic [1:0]                            status,
  output logic                                  last,
  output logic                                  full_res,
  output logic                                  empty_res
);
  import cqe_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t stat;

  assign cfg_ready = 1'b1;

  cqe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  cqe_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_capacity (capacity),
    .cmd          (cmd),
    .push_value   (push_value),
    .value        (value),
    .rear_value   (rear_value),
    .status       (status),
    .last         (last),
    .full_res     (full_res),
    .empty_res    (empty_res)
  );

endmodule

`default_nettype wire

// ===== test/tb_circular_queue_engine.sv =====
// ----------------------------------------------------------------------------
// tb_circular_queue_engine: self-checking bench for the circular queue engine
// Drives command words on the input channel and capacity writes on the
// configuration channel. A behavioural model of the ring predicts every
// result word, and a checker compares each result with the oldest
// prediction. Directed tests cover the empty queue, extreme words,
// overflow, out-of-range capacities and wrap-around. Random traffic then
// runs under three idling patterns and a long receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circular_queue_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import cqe_pkg::*;

  localparam int DEPTH       = 64;
  localparam int IDLE_LIMIT  = 4000;
  localparam int LONG_STALL  = 300;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    logic signed [WORD_W-1:0] word;
    logic signed [WORD_W-1:0] rear;
    status_t                  st;
    logic                     last;
    logic                     full;
    logic                     empty;
  } queue_result_t;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         capacity   = 7'd64;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  cmd_t                     cmd        = CMD_ENQ;
  logic signed [WORD_W-1:0] push_value = '0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  logic signed [WORD_W-1:0] value;
  logic signed [WORD_W-1:0] rear_value;
  logic [1:0]               status;
  logic                     last;
  logic                     full_res;
  logic                     empty_res;

  // Model of the ring, kept at the block's own widths.
  logic signed [WORD_W-1:0] ring_words [DEPTH];
  logic [5:0]               front_idx   = '0;
  logic [5:0]               back_idx    = '0;
  logic [6:0]               word_count  = '0;
  logic [CAP_W-1:0]         cap_setting = 7'd64;

  queue_result_t awaited_results [$];
  queue_result_t oldest;
  int            mismatch_count = 0;
  int            send_idle_pct  = 0;
  int            recv_idle_pct  = 0;
  int            stall_left     = 0;
  int            quiet_cycles   = 0;

  circular_queue_engine #(.DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .rear_value (rear_value),
    .status     (status),
    .last       (last),
    .full_res   (full_res),
    .empty_res  (empty_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic int usable_slots();
    if (cap_setting == 0) return 1;
    if (cap_setting > DEPTH) return DEPTH;
    return int'(cap_setting);
  endfunction

  function automatic logic [5:0] ring_next(logic [5:0] idx);
    int n;
    n = int'(idx) + 1;
    return (n >= usable_slots()) ? 6'd0 : n[5:0];
  endfunction

  // Flags reflect the state after the command has taken effect.
  function automatic void add_result(logic signed [WORD_W-1:0] w,
                                     logic signed [WORD_W-1:0] r,
                                     status_t s, logic l);
    queue_result_t res;
    res.word  = w;
    res.rear  = r;
    res.st    = s;
    res.last  = l;
    res.full  = (word_count >= usable_slots());
    res.empty = (word_count == 0);
    awaited_results.push_back(res);
  endfunction

  function automatic void predict_queue_op(cmd_t c, logic signed [WORD_W-1:0] pv);
    logic signed [WORD_W-1:0] w;
    logic [5:0]               idx;
    int                       rear;
    if (c == CMD_ENQ) begin
      if (word_count >= usable_slots()) begin
        add_result('0, '0, ST_OVERFLOW, 1'b1);
      end else begin
        ring_words[back_idx] = pv;
        back_idx = ring_next(back_idx);
        word_count++;
        add_result('0, '0, ST_OK, 1'b1);
      end
    end else if (word_count == 0) begin
      add_result('0, '0, ST_EMPTY, 1'b1);
    end else begin
      case (c)
        CMD_DEQ: begin
          w = ring_words[front_idx];
          word_count--;
          // A drained queue returns both indices to the first slot.
          if (word_count == 0) begin
            front_idx = '0;
            back_idx  = '0;
          end else begin
            front_idx = ring_next(front_idx);
          end
          add_result(w, '0, ST_OK, 1'b1);
        end
        CMD_PEEK: begin
          rear = (back_idx == 0) ? usable_slots() - 1 : int'(back_idx) - 1;
          add_result(ring_words[front_idx], ring_words[rear], ST_OK, 1'b1);
        end
        default: begin
          idx = front_idx;
          for (int n = 0; n < int'(word_count); n++) begin
            add_result(ring_words[idx], '0, ST_OK, (n + 1 == int'(word_count)));
            idx = ring_next(idx);
          end
        end
      endcase
    end
  endfunction

  // ------------------------------------------------------- channel drivers

  task automatic send_word(cmd_t c, logic signed [WORD_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    push_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_queue_op(c, v);
  endtask

  // Holds the sender back until every predicted result word has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    wait_for_results();
    cfg_valid <= 1'b1;
    capacity  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    cap_setting = c;
    front_idx   = '0;
    back_idx    = '0;
    word_count  = '0;
  endtask

  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t random_command(bit filling);
    int roll;
    roll = $urandom_range(99);
    if (roll < 8)  return CMD_PEEK;
    if (roll < 14) return CMD_DISP;
    if (roll < 82) return filling ? CMD_ENQ : CMD_DEQ;
    return filling ? CMD_DEQ : CMD_ENQ;
  endfunction

  // Runs of mostly enqueues alternate with runs of mostly dequeues, so the
  // queue travels between empty and full and the indices wrap.
  task automatic random_traffic(int count);
    bit filling;
    filling = 1'b1;
    repeat (count) begin
      if (word_count >= usable_slots()) filling = 1'b0;
      else if (word_count == 0) filling = 1'b1;
      else if ($urandom_range(19) == 0) filling = !filling;
      send_word(random_command(filling), random_word());
    end
  endtask

  // ------------------------------------------------------------ receiver

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result word with no command outstanding");
        mismatch_count++;
      end else begin
        oldest = awaited_results.pop_front();
        if (value !== oldest.word) begin
          $error("value: expected %0d, got %0d", oldest.word, value);
          mismatch_count++;
        end
        if (rear_value !== oldest.rear) begin
          $error("rear_value: expected %0d, got %0d", oldest.rear, rear_value);
          mismatch_count++;
        end
        if (status !== oldest.st) begin
          $error("status: expected %0d, got %0d", oldest.st, status);
          mismatch_count++;
        end
        if (last !== oldest.last) begin
          $error("last: expected %0d, got %0d", oldest.last, last);
          mismatch_count++;
        end
        if (full_res !== oldest.full) begin
          $error("full_res: expected %0d, got %0d", oldest.full, full_res);
          mismatch_count++;
        end
        if (empty_res !== oldest.empty) begin
          $error("empty_res: expected %0d, got %0d", oldest.empty, empty_res);
          mismatch_count++;
        end
      end
    end
  end

  // A run is considered hung once no word has moved on any channel for
  // far longer than the longest deliberate stall.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------- tests

  task automatic test_empty_queue();
    send_word(CMD_DEQ, 32'sd5);
    send_word(CMD_PEEK, -32'sd5);
    send_word(CMD_DISP, 32'sd0);
  endtask

  task automatic test_extreme_words();
    send_word(CMD_ENQ, 32'sh8000_0000);
    send_word(CMD_ENQ, 32'sh7fff_ffff);
    send_word(CMD_ENQ, 32'sd0);
    send_word(CMD_ENQ, -32'sd1);
    send_word(CMD_PEEK, 32'sd0);
    send_word(CMD_DISP, 32'sd0);
    repeat (4) send_word(CMD_DEQ, 32'sd0);
    send_word(CMD_DEQ, 32'sd0);
  endtask

  task automatic test_capacity_one();
    write_capacity(7'd1);
    send_word(CMD_ENQ, 32'sh1234_5678);
    send_word(CMD_ENQ, 32'sh0bad_cafe);
    send_word(CMD_DEQ, 32'sd0);
  endtask

  // A capacity of zero behaves as one slot; the rear then sits in slot zero.
  task automatic test_capacity_zero();
    write_capacity(7'd0);
    send_word(CMD_ENQ, -32'sd77);
    send_word(CMD_PEEK, 32'sd0);
  endtask

  task automatic test_ring_wrap();
    write_capacity(7'd3);
    send_word(CMD_ENQ, 32'sd11);
    send_word(CMD_ENQ, 32'sd22);
    send_word(CMD_ENQ, 32'sd33);
    send_word(CMD_PEEK, 32'sd0);
    send_word(CMD_DEQ, 32'sd0);
    send_word(CMD_ENQ, 32'sd44);
    send_word(CMD_DISP, 32'sd0);
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 35;
    recv_idle_pct = 70;
    write_capacity(7'd64);
    random_traffic(45);
    write_capacity(7'd5);
    random_traffic(45);
    send_idle_pct = 70;
    recv_idle_pct = 35;
    write_capacity(7'd127);
    random_traffic(45);
    write_capacity(7'd2);
    random_traffic(45);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(7'd1);
    random_traffic(45);
    write_capacity(7'($urandom_range(40, 6)));
    random_traffic(45);
  endtask

  // The receiver stops for a long stretch while commands keep coming, so
  // the engine holds a result and refuses further words; afterwards the
  // sender waits for every outstanding result before carrying on.
  task automatic test_backpressure();
    write_capacity(7'd8);
    stall_left = LONG_STALL;
    random_traffic(12);
    wait_for_results();
    random_traffic(8);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 35;
    recv_idle_pct = 70;
    test_empty_queue();
    test_extreme_words();
    test_capacity_one();
    test_capacity_zero();
    test_ring_wrap();
    test_random_traffic();
    test_backpressure();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/cqe_pkg.sv
rtl/cqe_datapath.sv
rtl/cqe_ctrl.sv
rtl/circular_queue_engine.sv
test/tb_circular_queue_engine.sv
